// ===== rtl/afr_pkg.sv =====
// shared types, codes and constants for the addressed frame receiver
package afr_pkg;

  localparam int FRAME_LEN = 15;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] START_BYTE = 8'h3a;
  localparam logic [7:0] END_BYTE = 8'h0a;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
  localparam logic [15:0] TICK_PRESCALE_LIMIT_RESET = 16'd3000;
  localparam logic [7:0] STALL_LIMIT_RESET = 8'd10;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_TICK_PRESCALE_LIMIT = 2'd1,
    CFG_STALL_LIMIT = 2'd2
  } afr_cfg_index_t;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ = 2'd3
  } afr_opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ARMED = 2'd1,
    PH_CAPTURE = 2'd2
  } afr_phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [3:0] read_index;
  } afr_item_t;

  typedef struct packed {
    logic frame_ready;
    logic check_pass;
    logic [7:0] read_data;
    logic receiving;
  } afr_result_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [15:0] tick_prescale_limit;
    logic [7:0] stall_limit;
  } afr_cfg_t;

endpackage

// ===== rtl/afr_cfg.sv =====
// configuration registers of the addressed frame receiver
module afr_cfg import afr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output afr_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEVICE_ADDRESS_RESET;
      cfg.tick_prescale_limit <= TICK_PRESCALE_LIMIT_RESET;
      cfg.stall_limit <= STALL_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[7:0];
        CFG_TICK_PRESCALE_LIMIT: cfg.tick_prescale_limit <= cfg_data[15:0];
        CFG_STALL_LIMIT: cfg.stall_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/afr_frame.sv =====
// receive state, frame buffer, stall timeout and result logic
module afr_frame import afr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  afr_item_t   item,
  input  afr_cfg_t    cfg,
  output afr_result_t result
);

  afr_phase_t rx_phase, rx_phase_next;
  logic [3:0] write_index, write_index_next;
  logic [7:0] frame_store [FRAME_LEN];
  logic [7:0] frame_store_next [FRAME_LEN];
  logic ready_flag, ready_flag_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic [7:0] stall_counter, stall_counter_next;

  afr_phase_t byte_phase;
  logic [7:0] sum_a, sum_b, read_byte;

  always_comb begin
    rx_phase_next = rx_phase;
    write_index_next = write_index;
    frame_store_next = frame_store;
    ready_flag_next = ready_flag;
    tick_counter_next = tick_counter;
    stall_counter_next = stall_counter;
    byte_phase = rx_phase;
    case (item.opcode)
      OP_BYTE: begin
        if (item.rx_byte == START_BYTE) begin
          byte_phase = PH_ARMED;
        end else if (item.rx_byte == cfg.device_address && rx_phase == PH_ARMED) begin
          byte_phase = PH_CAPTURE;
        end
        rx_phase_next = byte_phase;
        if (byte_phase == PH_CAPTURE) begin
          if (write_index < 4'(FRAME_LEN)) begin
            frame_store_next[write_index] = item.rx_byte;
          end
          write_index_next = write_index + 4'd1;
          if (write_index_next >= 4'(FRAME_LEN)) begin
            rx_phase_next = PH_IDLE;
            write_index_next = '0;
            if (item.rx_byte == END_BYTE) begin
              ready_flag_next = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (tick_counter < cfg.tick_prescale_limit) begin
          tick_counter_next = tick_counter + 16'd1;
        end else begin
          tick_counter_next = '0;
          if (rx_phase != PH_IDLE) begin
            if (stall_counter < cfg.stall_limit) begin
              stall_counter_next = stall_counter + 8'd1;
            end else begin
              stall_counter_next = '0;
              rx_phase_next = PH_IDLE;
              write_index_next = '0;
            end
          end
        end
      end
      OP_CLEAR: ready_flag_next = 1'b0;
      default: ;
    endcase
  end

  // check sums over the buffer as it stands after this item
  always_comb begin
    sum_a = frame_store_next[0] + frame_store_next[1];
    sum_b = ((frame_store_next[2] + frame_store_next[3])
           + (frame_store_next[4] + frame_store_next[5]))
          + ((frame_store_next[6] + frame_store_next[7])
           + (frame_store_next[8] + frame_store_next[9]))
          + frame_store_next[10];
  end

  always_comb begin
    read_byte = '0;
    if (item.opcode == OP_READ && item.read_index < 4'(FRAME_LEN)) begin
      read_byte = frame_store[item.read_index];
    end
  end

  always_comb begin
    result.frame_ready = ready_flag_next;
    result.check_pass = (sum_a == frame_store_next[12]) && (sum_b == frame_store_next[13]);
    result.read_data = read_byte;
    result.receiving = (rx_phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase <= PH_IDLE;
      write_index <= '0;
      ready_flag <= 1'b0;
      tick_counter <= '0;
      stall_counter <= '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame_store[i] <= '0;
      end
    end else if (go) begin
      rx_phase <= rx_phase_next;
      write_index <= write_index_next;
      ready_flag <= ready_flag_next;
      tick_counter <= tick_counter_next;
      stall_counter <= stall_counter_next;
      frame_store <= frame_store_next;
    end
  end

endmodule

// ===== rtl/addressed_frame_receiver.sv =====
// top level of the addressed frame receiver
//
//  channel  valid         stall         payload
//  item     item_valid    item_stall    item   (opcode, rx_byte, read_index)
//  result   result_valid  result_stall  result (frame_ready, check_pass,
//                                               read_data, receiving)
//
// an accepted item goes into the input register, then through one pass of the
// frame logic into the result register
// one item per cycle sustained while the result side does not stall; the frame
// logic updates its state as the item moves into the result register
// synchronous reset clears the receive state, buffer and counters and sets the config to its reset values
// a held result stalls the input register, which then stalls the item side
module addressed_frame_receiver import afr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  afr_item_t             item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output afr_result_t           result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  afr_cfg_t cfg;
  afr_item_t stage_item;
  logic stage_valid;
  logic advance;
  afr_result_t frame_result;

  assign advance = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && !advance;

  afr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afr_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (frame_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= frame_result;
    end
  end

  a_held_result_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && result_valid && result_stall) |-> item_stall)
    else $error("input register not stalled behind a held result");

  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_item.opcode != OP_READ) |=> (result.read_data == 8'd0))
    else $error("read data set for an item that is not a read");

  a_clear_drops_ready: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_item.opcode == OP_CLEAR) |=> (result_valid && !result.frame_ready))
    else $error("ready flag still set after a clear item");

endmodule

// ===== bench/addressed_frame_receiver_test.sv =====
// testbench for the addressed frame receiver: random and directed items against a shadow model
`timescale 1ns / 1ps

module addressed_frame_receiver_test;
  import afr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  afr_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  afr_result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the receiver state and registers
  logic [7:0] shadow_address = DEVICE_ADDRESS_RESET;
  logic [15:0] shadow_prescale = TICK_PRESCALE_LIMIT_RESET;
  logic [7:0] shadow_stall_limit = STALL_LIMIT_RESET;
  afr_phase_t shadow_phase = PH_IDLE;
  logic [3:0] shadow_wr_idx = '0;
  logic [7:0] shadow_store [FRAME_LEN] = '{default: 8'h00};
  logic shadow_ready = 1'b0;
  logic [15:0] shadow_ticks = '0;
  logic [7:0] shadow_stalls = '0;

  afr_result_t pending_results [$];
  afr_result_t oldest;
  int failures = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  addressed_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic afr_result_t frame_response(afr_item_t it);
    afr_result_t r;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    r = '0;
    case (it.opcode)
      OP_BYTE: begin
        if (it.rx_byte == START_BYTE) begin
          shadow_phase = PH_ARMED;
        end else if (it.rx_byte == shadow_address && shadow_phase == PH_ARMED) begin
          shadow_phase = PH_CAPTURE;
        end
        if (shadow_phase == PH_CAPTURE) begin
          if (shadow_wr_idx < FRAME_LEN) shadow_store[shadow_wr_idx] = it.rx_byte;
          shadow_wr_idx = shadow_wr_idx + 4'd1;
          if (shadow_wr_idx >= FRAME_LEN) begin
            shadow_phase = PH_IDLE;
            shadow_wr_idx = '0;
            if (it.rx_byte == END_BYTE) shadow_ready = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (shadow_ticks < shadow_prescale) begin
          shadow_ticks = shadow_ticks + 16'd1;
        end else begin
          shadow_ticks = '0;
          if (shadow_phase != PH_IDLE) begin
            if (shadow_stalls < shadow_stall_limit) begin
              shadow_stalls = shadow_stalls + 8'd1;
            end else begin
              shadow_stalls = '0;
              shadow_phase = PH_IDLE;
              shadow_wr_idx = '0;
            end
          end
        end
      end
      OP_CLEAR: begin
        shadow_ready = 1'b0;
      end
      default: begin
        r.read_data = (it.read_index < FRAME_LEN) ? shadow_store[it.read_index] : 8'h00;
      end
    endcase
    sum_a = shadow_store[0] + shadow_store[1];
    sum_b = '0;
    for (int i = 2; i < 11; i++) sum_b = sum_b + shadow_store[i];
    r.frame_ready = shadow_ready;
    r.check_pass = (sum_a == shadow_store[12]) && (sum_b == shadow_store[13]);
    r.receiving = (shadow_phase != PH_IDLE);
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("addressed_frame_receiver_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result %p with nothing expected", $time, result);
        failures++;
      end else begin
        oldest = pending_results.pop_front();
        failures += field_mismatch("frame_ready", 8'(oldest.frame_ready),
                                   8'(result.frame_ready));
        failures += field_mismatch("check_pass", 8'(oldest.check_pass),
                                   8'(result.check_pass));
        failures += field_mismatch("read_data", oldest.read_data, result.read_data);
        failures += field_mismatch("receiving", 8'(oldest.receiving),
                                   8'(result.receiving));
      end
    end
  end

  task automatic send_item(afr_opcode_t op, logic [7:0] rx, logic [3:0] idx);
    afr_item_t it;
    it.opcode = op;
    it.rx_byte = rx;
    it.read_index = idx;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(frame_response(it));
    sent_count++;
  endtask

  task automatic send_byte(logic [7:0] rx);
    send_item(OP_BYTE, rx, 4'($urandom_range(15)));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)));
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, 8'($urandom_range(255)), 4'($urandom_range(15)));
  endtask

  task automatic send_read(logic [3:0] idx);
    send_item(OP_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(afr_cfg_index_t idx, logic [15:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEVICE_ADDRESS: shadow_address = value[7:0];
      CFG_TICK_PRESCALE_LIMIT: shadow_prescale = value;
      default: shadow_stall_limit = value[7:0];
    endcase
  endtask

  // start byte then the first cut bytes of a frame, sums correct unless extras flips one
  task automatic send_frame(logic [7:0] addr, int cut, logic [7:0] tail, bit extras);
    logic [7:0] body [FRAME_LEN];
    int pick;
    body[0] = addr;
    body[1] = 8'($urandom_range(255));
    for (int i = 2; i < 12; i++) body[i] = 8'($urandom_range(255));
    body[12] = body[0] + body[1];
    body[13] = '0;
    for (int i = 2; i < 11; i++) body[13] = body[13] + body[i];
    body[14] = tail;
    if (extras) begin
      pick = $urandom_range(99);
      if (pick < 10) body[12] = body[12] ^ (8'h01 << $urandom_range(7));
      else if (pick < 20) body[13] = body[13] ^ (8'h01 << $urandom_range(7));
    end
    send_byte(START_BYTE);
    for (int i = 0; i < cut; i++) begin
      if (extras) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          send_tick();
        end else if (pick < 14) begin
          send_read(4'($urandom_range(15)));
        end else if (pick < 16) begin
          send_clear();
        end else if (pick < 19) begin
          send_byte(START_BYTE);
          send_byte(addr);
        end
      end
      send_byte(body[i]);
    end
  endtask

  task automatic test_reset_readback();
    send_read(4'd0);
    send_read(4'd14);
    send_read(4'd15);
  endtask

  task automatic test_good_frame();
    send_frame(8'd1, FRAME_LEN, END_BYTE, 1'b0);
    send_read(4'd0);
    send_read(4'd14);
    send_read(4'd15);
    send_clear();
  endtask

  task automatic test_bad_frames();
    send_frame(8'd1, FRAME_LEN, 8'h0b, 1'b0);
    // stray start mid frame keeps the write position
    send_byte(START_BYTE);
    send_byte(8'd1);
    send_byte(8'h22);
    send_byte(START_BYTE);
    send_byte(8'h77);
    send_byte(8'd1);
    send_read(4'd2);
    send_byte(8'hff);
  endtask

  task automatic test_address_cases();
    write_reg(CFG_DEVICE_ADDRESS, 16'(START_BYTE));
    send_byte(START_BYTE);
    send_byte(START_BYTE);
    send_byte(8'h55);
    send_read(4'd0);
    write_reg(CFG_DEVICE_ADDRESS, 16'h0000);
    send_byte(8'h00);
    send_frame(8'h00, FRAME_LEN, END_BYTE, 1'b0);
    write_reg(CFG_DEVICE_ADDRESS, 16'h00ff);
    send_byte(8'hff);
    send_frame(8'hff, FRAME_LEN, 8'hff, 1'b0);
    send_read(4'd14);
  endtask

  task automatic test_stall_timeout();
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'd0);
    write_reg(CFG_STALL_LIMIT, 16'd0);
    send_byte(START_BYTE);
    send_tick();
    send_tick();
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'hffff);
    write_reg(CFG_STALL_LIMIT, 16'h0020);
    send_byte(START_BYTE);
    repeat (3) send_tick();
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'd0);
    repeat (36) send_tick();
    // limit lowered below the running count
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'd3);
    write_reg(CFG_STALL_LIMIT, 16'd2);
    send_byte(START_BYTE);
    repeat (3) send_tick();
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'd1);
    repeat (8) send_tick();
  endtask

  task automatic run_random_phase(int sender_idle, int receiver_stall, int count);
    int target;
    int pick;
    logic [7:0] addr;
    logic [7:0] tail;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    addr = 8'($urandom_range(255));
    if (addr == START_BYTE) addr = addr + 8'd1;
    write_reg(CFG_DEVICE_ADDRESS, 16'(addr));
    write_reg(CFG_TICK_PRESCALE_LIMIT, 16'($urandom_range(3)));
    write_reg(CFG_STALL_LIMIT, 16'($urandom_range(5)));
    target = sent_count + count;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        tail = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : END_BYTE;
        send_frame(addr, FRAME_LEN, tail, 1'b1);
      end else if (pick < 65) begin
        send_frame(addr, $urandom_range(FRAME_LEN - 1, 1), END_BYTE, 1'b1);
        repeat ($urandom_range(8, 1)) send_tick();
      end else if (pick < 72) begin
        repeat (4) send_read(4'($urandom_range(15)));
      end else begin
        send_item(afr_opcode_t'($urandom_range(3)), 8'($urandom_range(255)),
                  4'($urandom_range(15)));
      end
    end
    drain_results();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(0, 0, 70);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(74, 0, 70);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(0, 74, 70);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(37, 37, 70);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_readback();
    test_good_frame();
    test_bad_frames();
    test_address_cases();
    test_stall_timeout();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("addressed_frame_receiver_test passed");
    end else begin
      $display("addressed_frame_receiver_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/afr_pkg.sv
rtl/afr_cfg.sv
rtl/afr_frame.sv
rtl/addressed_frame_receiver.sv
bench/addressed_frame_receiver_test.sv
